// ===== rtl/unsorted_list_table_core_defines.svh =====
// Assertion macros used by the checker file of the list table.
`ifndef UNSORTED_LIST_TABLE_CORE_DEFINES_SVH
`define UNSORTED_LIST_TABLE_CORE_DEFINES_SVH

// Clocked assertion, disabled while reset is high.
`define ULT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A stalled word keeps its valid and its payload.
`define ULT_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

// ===== rtl/ult_pkg.sv =====
// ----------------------------------------------------------------------------
// ult_pkg
// Types, sizes and codes shared by the unsorted list table modules.
// ----------------------------------------------------------------------------
package ult_pkg;

  localparam int DEPTH      = 16;
  localparam int ITEM_WIDTH = 32;

  localparam int PORT_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;
  localparam int EC_W   = 5;
  localparam int VAL_W  = (ITEM_WIDTH < PORT_W) ? ITEM_WIDTH : PORT_W;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int QDEPTH = 2;
  localparam int QIDX_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 3'd0,
    CMD_DELETE     = 3'd1,
    CMD_LOOKUP     = 3'd2,
    CMD_CLEAR      = 3'd3,
    CMD_RESET_ITER = 3'd4,
    CMD_NEXT       = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INSERT,
    OP_DELETE,
    OP_LOOKUP,
    OP_CLEAR,
    OP_RESET_ITER,
    OP_NEXT
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_NEXT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
  } work_t;

endpackage

// ===== rtl/ult_front.sv =====
// ----------------------------------------------------------------------------
// ult_front
// Accepts command words and classifies them into internal operations.
// ----------------------------------------------------------------------------
module ult_front (
  input  logic                      cmd_valid,
  output logic                      cmd_ready,
  input  logic [ult_pkg::CMD_W-1:0] cmd,
  input  logic [ult_pkg::PORT_W-1:0] item_in,
  output logic                      push_valid,
  input  logic                      push_ready,
  output ult_pkg::work_t            push_data
);
  import ult_pkg::*;

  op_t op;

  always_comb begin
    unique case (cmd)
      CMD_INSERT:     op = OP_INSERT;
      CMD_DELETE:     op = OP_DELETE;
      CMD_LOOKUP:     op = OP_LOOKUP;
      CMD_CLEAR:      op = OP_CLEAR;
      CMD_RESET_ITER: op = OP_RESET_ITER;
      CMD_NEXT:       op = OP_NEXT;
      default:        op = OP_NOP;
    endcase
  end

  // Only the low item bits take part in storage and compares.
  assign push_data.op    = op;
  assign push_data.value = item_in[VAL_W-1:0];
  assign push_valid      = cmd_valid;
  assign cmd_ready       = push_ready;

endmodule

// ===== rtl/ult_queue.sv =====
// ----------------------------------------------------------------------------
// ult_queue
// Short FIFO of classified operations between the front and the back.
// ----------------------------------------------------------------------------
module ult_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  ult_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ult_pkg::work_t pop_data
);
  import ult_pkg::*;

  work_t              slots [QDEPTH];
  logic [QIDX_W-1:0]  wr_ptr;
  logic [QIDX_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (fill != QCNT_W'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : wr_ptr + QIDX_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QIDX_W'(QDEPTH - 1)) ? '0 : rd_ptr + QIDX_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/ult_back.sv =====
// ----------------------------------------------------------------------------
// ult_back
// Executes list operations against the entry memory and holds the result word.
// ----------------------------------------------------------------------------
module ult_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  ult_pkg::work_t             pop_data,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [ult_pkg::ST_W-1:0]   status,
  output logic                       found,
  output logic [ult_pkg::PORT_W-1:0] item_out,
  output logic [ult_pkg::EC_W-1:0]   entry_count,
  output logic                       is_full
);
  import ult_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rd_data;

  state_t           state, state_next;
  work_t            cur, cur_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] iter_pos, iter_pos_next;
  logic             iter_started, iter_started_next;
  logic [IDX_W-1:0] scan_ptr, scan_ptr_next;

  logic [IDX_W-1:0] rd_idx;
  logic             we;
  logic [IDX_W-1:0] wa;
  logic [VAL_W-1:0] wd;

  logic             res_load;
  status_t          res_status;
  logic             res_found;
  logic [VAL_W-1:0] res_item;
  logic [CNT_W-1:0] res_count;

  status_t          out_status;
  logic             out_found;
  logic [VAL_W-1:0] out_item;
  logic [CNT_W-1:0] out_count;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] pos_n;
  logic [CNT_W-1:0] iter_off;
  logic [CNT_W-1:0] sp_p1;
  logic [CNT_W-1:0] sp_p2;

  assign cnt_m1 = count - CNT_W'(1);
  assign sp_p1  = CNT_W'(scan_ptr) + CNT_W'(1);
  assign sp_p2  = CNT_W'(scan_ptr) + CNT_W'(2);

  always_comb begin
    if (!iter_started) begin
      pos_n = '0;
    end else if (iter_pos < CNT_W'(DEPTH)) begin
      pos_n = iter_pos + CNT_W'(1);
    end else begin
      pos_n = iter_pos;
    end
  end

  assign iter_off = cnt_m1 - pos_n;

  // A new operation starts only when the result register will be free.
  assign pop_ready = (state == S_IDLE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      iter_pos     <= '0;
      iter_started <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      count        <= count_next;
      iter_pos     <= iter_pos_next;
      iter_started <= iter_started_next;
      if (res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    scan_ptr <= scan_ptr_next;
    if (res_load) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_item   <= res_item;
      out_count  <= res_count;
    end
  end

  always_comb begin
    state_next        = state;
    cur_next          = cur;
    count_next        = count;
    iter_pos_next     = iter_pos;
    iter_started_next = iter_started;
    scan_ptr_next     = scan_ptr;
    rd_idx            = cnt_m1[IDX_W-1:0];
    we                = 1'b0;
    wa                = count[IDX_W-1:0];
    wd                = pop_data.value;
    res_load          = 1'b0;
    res_status        = ST_OK;
    res_found         = 1'b0;
    res_item          = '0;
    res_count         = count;

    unique case (state)
      S_IDLE: begin
        if (pop_valid && pop_ready) begin
          cur_next = pop_data;
          unique case (pop_data.op)
            OP_INSERT: begin
              res_load = 1'b1;
              if (count >= CNT_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                we         = 1'b1;
                count_next = count + CNT_W'(1);
                res_count  = count + CNT_W'(1);
              end
            end
            OP_DELETE, OP_LOOKUP: begin
              if (count == '0) begin
                res_load   = 1'b1;
                res_status = ST_NOT_FOUND;
              end else begin
                scan_ptr_next = cnt_m1[IDX_W-1:0];
                state_next    = S_SCAN;
              end
            end
            OP_CLEAR: begin
              res_load          = 1'b1;
              count_next        = '0;
              res_count         = '0;
              iter_pos_next     = '0;
              iter_started_next = 1'b0;
            end
            OP_RESET_ITER: begin
              res_load          = 1'b1;
              iter_pos_next     = '0;
              iter_started_next = 1'b0;
            end
            OP_NEXT: begin
              iter_pos_next     = pos_n;
              iter_started_next = 1'b1;
              if (pos_n < count) begin
                rd_idx     = iter_off[IDX_W-1:0];
                state_next = S_NEXT;
              end else begin
                res_load   = 1'b1;
                res_status = ST_EXHAUSTED;
              end
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds the entry at scan_ptr; the scan runs newest to oldest.
        if (rd_data == cur.value) begin
          if (cur.op == OP_LOOKUP) begin
            res_load   = 1'b1;
            res_found  = 1'b1;
            state_next = S_IDLE;
          end else if (sp_p1 < count) begin
            rd_idx     = sp_p1[IDX_W-1:0];
            state_next = S_SHIFT;
          end else begin
            res_load   = 1'b1;
            res_found  = 1'b1;
            count_next = cnt_m1;
            res_count  = cnt_m1;
            state_next = S_IDLE;
          end
        end else if (scan_ptr == '0) begin
          res_load   = 1'b1;
          res_status = ST_NOT_FOUND;
          state_next = S_IDLE;
        end else begin
          rd_idx        = scan_ptr - IDX_W'(1);
          scan_ptr_next = scan_ptr - IDX_W'(1);
        end
      end

      S_SHIFT: begin
        // Close the gap: each newer entry moves down by one slot.
        we = 1'b1;
        wa = scan_ptr;
        wd = rd_data;
        if (sp_p2 < count) begin
          rd_idx        = sp_p2[IDX_W-1:0];
          scan_ptr_next = sp_p1[IDX_W-1:0];
        end else begin
          res_load   = 1'b1;
          res_found  = 1'b1;
          count_next = cnt_m1;
          res_count  = cnt_m1;
          state_next = S_IDLE;
        end
      end

      S_NEXT: begin
        res_load   = 1'b1;
        res_item   = rd_data;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign status      = out_status;
  assign found       = out_found;
  assign item_out    = PORT_W'(out_item);
  assign entry_count = EC_W'(out_count);
  assign is_full     = (out_count == CNT_W'(DEPTH));

endmodule

// ===== rtl/unsorted_list_table_core.sv =====
// A word passes through the queue to the back end. Insert, clear, iterator reset
// and unknown commands finish in the idle state; next item returns its entry from S_NEXT.
// Lookup and delete scan entries newest to oldest, and delete then moves each newer
// entry down by one slot. Throughput: one word a cycle for commands that finish in
// the idle state while results are taken; the back end runs one operation at a time.
// Reset clears count, iterator, queue and result; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// unsorted_list_table_core
// Bounded unsorted list with insert, delete, lookup, clear and an iterator.
// ----------------------------------------------------------------------------
module unsorted_list_table_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic [ult_pkg::CMD_W-1:0]  cmd,
  input  logic [ult_pkg::PORT_W-1:0] item_in,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [ult_pkg::ST_W-1:0]   status,
  output logic                       found,
  output logic [ult_pkg::PORT_W-1:0] item_out,
  output logic [ult_pkg::EC_W-1:0]   entry_count,
  output logic                       is_full
);
  import ult_pkg::*;

  logic  push_valid;
  logic  push_ready;
  work_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  work_t pop_data;

  ult_front u_front (
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .item_in    (item_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ult_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  ult_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .found        (found),
    .item_out     (item_out),
    .entry_count  (entry_count),
    .is_full      (is_full)
  );

endmodule

// ===== rtl/ult_checker.sv =====
// ----------------------------------------------------------------------------
// ult_checker
// Port-level checks on the command and result words of the list table.
// ----------------------------------------------------------------------------
`include "unsorted_list_table_core_defines.svh"

module ult_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       cmd_valid,
  input logic                       cmd_ready,
  input logic [ult_pkg::CMD_W-1:0]  cmd,
  input logic [ult_pkg::PORT_W-1:0] item_in,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [ult_pkg::ST_W-1:0]   status,
  input logic                       found,
  input logic [ult_pkg::PORT_W-1:0] item_out,
  input logic [ult_pkg::EC_W-1:0]   entry_count,
  input logic                       is_full
);
  import ult_pkg::*;

  logic [ST_W+PORT_W+EC_W+1:0] payload;
  logic [CMD_W+PORT_W-1:0]     cmd_word;
  logic                        at_depth;
  logic                        full_word;

  assign payload   = {status, found, item_out, entry_count, is_full};
  assign cmd_word  = {cmd, item_in};
  assign at_depth  = (entry_count == EC_W'(DEPTH));
  assign full_word = result_valid && (status == ST_FULL);

  `ULT_ASSERT_HOLD(a_cmd_hold, cmd_valid, cmd_ready, cmd_word, "command word not held")
  `ULT_ASSERT_HOLD(a_result_hold, result_valid, result_ready, payload, "result word not held")
  `ULT_ASSERT(a_full_flag, result_valid |-> (is_full == at_depth), "bad full flag")
  `ULT_ASSERT(a_count_bound, result_valid |-> (entry_count <= EC_W'(DEPTH)), "count above depth")
  `ULT_ASSERT(a_full_status, full_word |-> (is_full && !found), "bad full status")

endmodule

bind unsorted_list_table_core ult_checker u_checker (.*);
